// File: src/tbrl_pkg.sv
// Package for the token bucket rate limiter: status codes, register indexes,
// reset values and fixed widths. No dependencies.
package tbrl_pkg;

    localparam int CREDIT_W   = 34;
    localparam int LEVEL_W    = 33;
    localparam int RATE_W     = 24;
    localparam int CAP_W      = 32;
    localparam int TICKS_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(10486);
    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(10485760);

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CAP  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_GRANTED  = 2'd1,
        ST_WAITING  = 2'd2,
        ST_REFUSED  = 2'd3
    } t_status;

endpackage

// File: src/tbrl_if.sv
// Valid/ready channel interfaces of the token bucket rate limiter.
// Depends on tbrl_pkg for the status type and fixed widths.
interface tbrl_in_if #(parameter int REQ_W = 24) ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [REQ_W-1:0] request_bytes;

    modport source (output valid, op, request_bytes, input ready);
    modport sink   (input valid, op, request_bytes, output ready);
endinterface

interface tbrl_out_if #(parameter int REQ_W = 24) ();
    logic                                   valid;
    logic                                   ready;
    tbrl_pkg::t_status                      status;
    logic [REQ_W-1:0]                       granted_bytes;
    logic signed [tbrl_pkg::LEVEL_W-1:0]    token_level;
    logic                                   request_pending;
    logic [tbrl_pkg::TICKS_W-1:0]           throttle_ticks;

    modport source (output valid, status, granted_bytes, token_level, request_pending,
                    throttle_ticks, input ready);
    modport sink   (input valid, status, granted_bytes, token_level, request_pending,
                    throttle_ticks, output ready);
endinterface

interface tbrl_cfg_if ();
    logic                              valid;
    logic                              ready;
    logic [tbrl_pkg::CFG_IDX_W-1:0]    index;
    logic [tbrl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/token_bucket_rate_limiter.sv
// Token bucket rate limiter with debt: tick and request transactions in,
// one status transaction out per input. Depends on tbrl_pkg and tbrl_if.
// The result is registered, valid in the cycle after input accept; throughput 1 transaction/cycle.
// The credit register update (refill add, clamp, threshold compare, debit) is
// one combinational pass, so a new transaction is taken every cycle while the
// output register is empty or being drained. Config writes are registered.
// Reset (i_rst_n low, synchronous): credit = capacity = 10485760, rate = 10486,
// no request pending, throttle count zero, output empty.
module token_bucket_rate_limiter #(
    parameter int REQUEST_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbrl_cfg_if.sink     i_cfg,
    tbrl_in_if.sink      i_in,
    tbrl_out_if.source   o_out
);
    import tbrl_pkg::*;

    localparam int PAD_W = CREDIT_W - REQUEST_BITS;

    // configuration
    logic [RATE_W-1:0]          r_rate;
    logic [CAP_W-1:0]           r_cap;

    // bucket state
    logic signed [CREDIT_W-1:0] r_credit, n_credit;
    logic                       r_waiting, n_waiting;
    logic [REQUEST_BITS-1:0]    r_wait_size, n_wait_size;
    logic [TICKS_W-1:0]         r_wait_ticks, n_wait_ticks;

    // output register
    logic                       r_out_valid;
    t_status                    r_status, n_status;
    logic [REQUEST_BITS-1:0]    r_granted, n_granted;
    logic signed [LEVEL_W-1:0]  r_level;
    logic                       r_pending;
    logic [TICKS_W-1:0]         r_ticks;

    logic                       in_fire;
    logic                       cfg_fire;

    // grant check operands
    logic signed [CREDIT_W-1:0] cap_s;
    logic signed [CREDIT_W-1:0] refill;
    logic signed [CREDIT_W-1:0] base_credit;
    logic [REQUEST_BITS-1:0]    chk_size;
    logic signed [CREDIT_W-1:0] chk_size_s;
    logic signed [CREDIT_W-1:0] thr;
    logic                       grant_ok;

    // Config port is always open; writes must only happen while idle, which the block does not enforce.
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    // One-entry output register: take a new transaction when it is empty or draining.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        cap_s  = $signed({{(CREDIT_W-CAP_W){1'b0}}, r_cap});
        refill = r_credit + $signed({{(CREDIT_W-RATE_W){1'b0}}, r_rate});
        if (refill > cap_s) begin
            refill = cap_s;
        end

        // A tick checks the held request against the refilled bucket;
        // a fresh request checks its own size against the current credit.
        if (i_in.op == OP_TICK) begin
            base_credit = refill;
            chk_size    = r_wait_size;
        end else begin
            base_credit = r_credit;
            chk_size    = i_in.request_bytes;
        end

        chk_size_s = $signed({{PAD_W{1'b0}}, chk_size});
        thr        = (chk_size_s < cap_s) ? chk_size_s : cap_s;
        grant_ok   = base_credit >= thr;

        n_credit     = r_credit;
        n_waiting    = r_waiting;
        n_wait_size  = r_wait_size;
        n_wait_ticks = r_wait_ticks;
        n_status     = ST_NONE;
        n_granted    = '0;

        if (i_in.op == OP_TICK) begin
            n_credit = refill;
            if (r_waiting) begin
                if (r_wait_ticks != {TICKS_W{1'b1}}) begin
                    n_wait_ticks = r_wait_ticks + TICKS_W'(1);
                end
                if (grant_ok) begin
                    n_credit    = refill - chk_size_s;
                    n_status    = ST_GRANTED;
                    n_granted   = r_wait_size;
                    n_waiting   = 1'b0;
                    n_wait_size = '0;
                end else begin
                    n_status = ST_WAITING;
                end
            end
        end else if (r_waiting) begin
            // busy: refuse, state untouched
            n_status = ST_REFUSED;
        end else if (grant_ok) begin
            n_credit  = r_credit - chk_size_s;
            n_status  = ST_GRANTED;
            n_granted = i_in.request_bytes;
        end else begin
            n_status    = ST_WAITING;
            n_waiting   = 1'b1;
            n_wait_size = i_in.request_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate       <= RATE_RESET;
            r_cap        <= CAP_RESET;
            r_credit     <= $signed({{(CREDIT_W-CAP_W){1'b0}}, CAP_RESET});
            r_waiting    <= 1'b0;
            r_wait_size  <= '0;
            r_wait_ticks <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_fire) begin
                if (i_cfg.index == REG_RATE) begin
                    r_rate <= i_cfg.data[RATE_W-1:0];
                end else if (i_cfg.index == REG_CAP) begin
                    r_cap    <= i_cfg.data[CAP_W-1:0];
                    r_credit <= $signed({{(CREDIT_W-CAP_W){1'b0}}, i_cfg.data[CAP_W-1:0]});
                end
            end else if (in_fire) begin
                r_credit     <= n_credit;
                r_waiting    <= n_waiting;
                r_wait_size  <= n_wait_size;
                r_wait_ticks <= n_wait_ticks;
            end

            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_level   <= n_credit[LEVEL_W-1:0];
            r_pending <= n_waiting;
            r_ticks   <= n_wait_ticks;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.granted_bytes   = r_granted;
    assign o_out.token_level     = r_level;
    assign o_out.request_pending = r_pending;
    assign o_out.throttle_ticks  = r_ticks;

    // credit never rises above capacity
    a_credit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= cap_s)
        else $error("credit above capacity");

    // a refused request leaves the held request alone
    a_refuse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !cfg_fire && i_in.op == OP_REQUEST && r_waiting)
        |=> (r_waiting && $stable(r_wait_size) && $stable(r_credit)))
        else $error("refused request changed state");

    // ticks only counted while a request is held
    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !cfg_fire && !r_waiting) |=> $stable(r_wait_ticks))
        else $error("throttle count moved with nothing pending");

    // a waiting result always reports the request as pending
    a_wait_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_WAITING) |-> r_pending)
        else $error("waiting status without pending flag");

    // a grant result never leaves a request pending
    a_grant_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_GRANTED) |-> !r_pending)
        else $error("grant left a request pending");

endmodule

// File: verif/tbrl_checker.sv
// Passive checker for the token bucket rate limiter: tracks config writes, predicts one
// result per accepted input transaction and compares it with the output channel.
// Depends on tbrl_pkg and the channel interfaces in tbrl_if.
module tbrl_checker #(
    parameter int REQUEST_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tbrl_cfg_if  i_cfg,
    tbrl_in_if   i_in,
    tbrl_out_if  i_out,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked,
    output int   o_grants,
    output int   o_waits,
    output int   o_refusals
);
    timeunit 1ns;
    timeprecision 1ps;
    import tbrl_pkg::*;

    typedef struct packed {
        t_status                     status;
        logic [REQUEST_BITS-1:0]     granted;
        logic signed [LEVEL_W-1:0]   level;
        logic                        pending;
        logic [TICKS_W-1:0]          ticks;
    } t_limiter_result;

    // shadow copy of the limiter
    logic [RATE_W-1:0]          shadow_rate;
    logic [CAP_W-1:0]           shadow_cap;
    logic signed [CREDIT_W-1:0] shadow_credit;
    logic                       shadow_waiting;
    logic [REQUEST_BITS-1:0]    shadow_waiting_bytes;
    logic [TICKS_W-1:0]         shadow_throttle;

    t_limiter_result awaited_results[$];
    int fail_count, checked, grants, waits, refusals;

    // debit when credit covers min(bytes, capacity); credit may go negative
    function automatic bit debit_if_covered(logic [REQUEST_BITS-1:0] bytes);
        logic [CAP_W-1:0] threshold;
        threshold = (CAP_W'(bytes) < shadow_cap) ? CAP_W'(bytes) : shadow_cap;
        if (shadow_credit >= $signed({2'b00, threshold})) begin
            shadow_credit = shadow_credit
                          - $signed({{(CREDIT_W-REQUEST_BITS){1'b0}}, bytes});
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_limiter_result predict_result(logic op,
                                                       logic [REQUEST_BITS-1:0] bytes);
        t_limiter_result r;
        r.status  = ST_NONE;
        r.granted = '0;
        if (op == OP_TICK) begin
            shadow_credit = shadow_credit + $signed({{(CREDIT_W-RATE_W){1'b0}}, shadow_rate});
            if (shadow_credit > $signed({2'b00, shadow_cap}))
                shadow_credit = {2'b00, shadow_cap};
            if (shadow_waiting) begin
                if (shadow_throttle != '1)
                    shadow_throttle = shadow_throttle + TICKS_W'(1);
                if (debit_if_covered(shadow_waiting_bytes)) begin
                    r.status             = ST_GRANTED;
                    r.granted            = shadow_waiting_bytes;
                    shadow_waiting       = 1'b0;
                    shadow_waiting_bytes = '0;
                end else begin
                    r.status = ST_WAITING;
                end
            end
        end else if (shadow_waiting) begin
            r.status = ST_REFUSED;
        end else if (debit_if_covered(bytes)) begin
            r.status  = ST_GRANTED;
            r.granted = bytes;
        end else begin
            r.status             = ST_WAITING;
            shadow_waiting       = 1'b1;
            shadow_waiting_bytes = bytes;
        end
        r.level   = shadow_credit[LEVEL_W-1:0];
        r.pending = shadow_waiting;
        r.ticks   = shadow_throttle;
        return r;
    endfunction

    task automatic flag_mismatch(string field, longint expected_val, longint actual_val);
        $error("%s mismatch: expected %0d, got %0d", field, expected_val, actual_val);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_limiter_result want;
        if (!i_rst_n) begin
            shadow_rate          = RATE_RESET;
            shadow_cap           = CAP_RESET;
            shadow_credit        = {2'b00, CAP_RESET};
            shadow_waiting       = 1'b0;
            shadow_waiting_bytes = '0;
            shadow_throttle      = '0;
            awaited_results.delete();
        end else begin
            // result first: the DUT registers its result, so it never belongs to this edge's input
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    fail_count++;
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    checked++;
                    if (i_out.status !== want.status)
                        flag_mismatch("status", want.status, i_out.status);
                    if (i_out.granted_bytes !== want.granted)
                        flag_mismatch("granted_bytes", want.granted, i_out.granted_bytes);
                    if (i_out.token_level !== want.level)
                        flag_mismatch("token_level", longint'($signed(want.level)),
                                      longint'($signed(i_out.token_level)));
                    if (i_out.request_pending !== want.pending)
                        flag_mismatch("request_pending", want.pending,
                                      i_out.request_pending);
                    if (i_out.throttle_ticks !== want.ticks)
                        flag_mismatch("throttle_ticks", want.ticks, i_out.throttle_ticks);
                end
            end
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                if (i_cfg.index == REG_RATE) begin
                    shadow_rate = i_cfg.data[RATE_W-1:0];
                end else if (i_cfg.index == REG_CAP) begin
                    shadow_cap    = i_cfg.data[CAP_W-1:0];
                    shadow_credit = {2'b00, i_cfg.data[CAP_W-1:0]};
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                want = predict_result(i_in.op, i_in.request_bytes);
                unique case (want.status)
                    ST_GRANTED: grants++;
                    ST_WAITING: waits++;
                    ST_REFUSED: refusals++;
                    default: ;
                endcase
                awaited_results.insert(awaited_results.size(), want);
            end
        end
        o_outstanding <= awaited_results.size();
        o_fail_count  <= fail_count;
        o_checked     <= checked;
        o_grants      <= grants;
        o_waits       <= waits;
        o_refusals    <= refusals;
    end

endmodule

// File: verif/testbench.sv
// Top of the token bucket rate limiter testbench: clock, reset, stimulus and verdict.
// Depends on tbrl_pkg, tbrl_if, the limiter RTL and tbrl_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tbrl_pkg::*;

    localparam int REQUEST_BITS = 24;
    localparam int DUT_LATENCY  = 1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // per-cycle idle chances, in percent
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    int items_sent = 0;
    int reg_writes = 0;

    int fail_count, outstanding, checked, grants, waits, refusals;

    tbrl_in_if #(.REQ_W(REQUEST_BITS))  in_ch ();
    tbrl_out_if #(.REQ_W(REQUEST_BITS)) out_ch ();
    tbrl_cfg_if                         cfg_ch ();

    token_bucket_rate_limiter #(
        .REQUEST_BITS(REQUEST_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tbrl_checker #(
        .REQUEST_BITS(REQUEST_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg_ch),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_grants      (grants),
        .o_waits       (waits),
        .o_refusals    (refusals)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side backpressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #400_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One input transaction. Idle cycles are inserted at random before it; valid stays
    // high after acceptance so back-to-back transactions see no bubble.
    task automatic present_item(logic op, logic [REQUEST_BITS-1:0] bytes);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= op;
        in_ch.request_bytes <= bytes;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
    endtask

    // Hold off the sender until every predicted result has come back, then let the
    // pipeline settle.
    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DUT_LATENCY + 2) @(posedge i_clk);
    endtask

    // Register writes only happen with the limiter idle.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        repeat (DUT_LATENCY + 1) @(posedge i_clk);
        reg_writes++;
    endtask

    // Random traffic under one idle profile. Wide mode uses a large bucket so that
    // full-range request sizes still get repaid within a few dozen ticks; narrow mode
    // keeps the bucket small so waits, debt and busy refusals come often.
    task automatic run_phase(int src_pct, int sink_pct, bit wide, int count);
        logic [CAP_W-1:0]        cap;
        logic [RATE_W-1:0]       rate;
        logic [REQUEST_BITS-1:0] bytes;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        if (wide) begin
            cap  = $urandom_range(1 << 20, 1 << 26);
            rate = RATE_W'($urandom_range(1 << 18, 1 << 23));
        end else begin
            cap  = $urandom_range(1, 4096);
            rate = RATE_W'($urandom_range(1, cap));
        end
        // upper data bits above the rate field are junk and must be dropped
        write_register(REG_RATE, {8'($urandom), rate});
        write_register(REG_CAP + CFG_IDX_W'($urandom_range(1, 254)), $urandom);
        write_register(REG_CAP, cap);
        for (int n = 0; n < count; n++) begin
            // mid-phase: sender waits for all results before carrying on
            if (n == count / 2)
                wait_until_drained();
            if (wide)
                bytes = REQUEST_BITS'($urandom);
            else if ($urandom_range(9) == 0)
                bytes = '0;
            else
                bytes = REQUEST_BITS'($urandom_range(0, cap + cap / 2));
            if ($urandom_range(99) < 45)
                present_item(OP_TICK, REQUEST_BITS'($urandom));
            else
                present_item(OP_REQUEST, bytes);
        end
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.op            = OP_TICK;
        in_ch.request_bytes = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_RATE;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        i_rst_n             = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 10;
        sink_idle_pct = 47;

        // ---- directed part, reset config: full bucket of 10 MiB ----
        present_item(OP_TICK, '0);                      // tick at full bucket, clamps
        present_item(OP_REQUEST, '0);                   // zero-byte request
        present_item(OP_REQUEST, {REQUEST_BITS{1'b1}}); // above capacity: threshold capped,
                                                        // credit goes deep negative
        present_item(OP_REQUEST, REQUEST_BITS'(1));     // in debt: waits
        present_item(OP_REQUEST, REQUEST_BITS'(5));     // busy: refused
        present_item(OP_TICK, {REQUEST_BITS{1'b1}});    // still waiting, tick counted

        // max rate, upper data bits set: one tick repays the debt and grants
        write_register(REG_RATE, '1);
        present_item(OP_TICK, '0);

        // largest capacity: level reaches its top
        write_register(REG_CAP, '1);
        present_item(OP_TICK, '0);
        present_item(OP_REQUEST, {REQUEST_BITS{1'b1}});

        // capacity zero: threshold zero, ticks clamp at zero
        write_register(REG_CAP, '0);
        present_item(OP_REQUEST, '0);
        present_item(OP_REQUEST, REQUEST_BITS'(100));
        present_item(OP_TICK, '0);
        present_item(OP_REQUEST, REQUEST_BITS'(7));
        present_item(OP_REQUEST, REQUEST_BITS'(3));
        present_item(OP_TICK, '0);

        // rate zero: a pending request stalls until the rate comes back
        write_register(REG_RATE, '0);
        write_register(REG_CAP, CFG_DATA_W'(5));
        present_item(OP_REQUEST, REQUEST_BITS'(6));
        present_item(OP_REQUEST, REQUEST_BITS'(2));
        present_item(OP_TICK, '0);
        present_item(OP_TICK, '0);
        write_register(REG_RATE, CFG_DATA_W'(1));
        present_item(OP_TICK, '0);
        present_item(OP_TICK, '0);
        present_item(OP_TICK, '0);
        write_register(REG_CAP + 1'b1, '1);             // unmapped index, ignored

        // ---- random part across three idle profiles ----
        run_phase(10, 47, 1'b0, 184);
        run_phase(47, 10, 1'b1, 183);
        run_phase(0, 0, 1'b0, 183);

        wait_until_drained();
        repeat (DUT_LATENCY + 4) @(posedge i_clk);

        $display("Coverage: %0d input transactions, %0d results compared",
                 items_sent, checked);
        $display("Coverage: %0d grants, %0d waits, %0d busy refusals, %0d register writes",
                 grants, waits, refusals, reg_writes);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
